// ===== design/playfair_digraph_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// playfair cipher assertion macros
// shared concurrent check forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PFC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// word types, function codes and letter constants of the playfair cipher
// ----------------------------------------------------------------------------
package pfc_pkg;

    // input word function codes
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_KEY    = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_TEXT   = 2'd3
    } pfc_func_t;

    // input word
    typedef struct packed {
        pfc_func_t   func;
        logic [4:0]  letter;
        logic        last;
    } pfc_in_t;

    // result word
    typedef struct packed {
        logic [4:0]  out_letter;
        logic        out_last;
    } pfc_out_t;

    // letter codes
    localparam logic [4:0] LET_I = 5'd8;
    localparam logic [4:0] LET_J = 5'd9;
    localparam logic [4:0] LET_X = 5'd23;
    localparam logic [4:0] LET_Z = 5'd25;

    // grid geometry
    localparam int         ALPHA_N = 26;
    localparam logic [4:0] GRID_N  = 5'd25;
    localparam logic [2:0] SIDE    = 3'd5;

endpackage

// ===== design/pfc_out_stage.sv =====
// ----------------------------------------------------------------------------
// pfc_out_stage
// result register between the cipher sequencer and the m_ channel
// ----------------------------------------------------------------------------
module pfc_out_stage import pfc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  pfc_out_t push_word,
    output logic     space,
    output logic     m_valid,
    input  logic     m_ready,
    output pfc_out_t m_data
);

    logic     valid_reg;
    pfc_out_t word_reg;

    // room when empty or draining this cycle
    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = word_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (push) begin
            word_reg <= push_word;
        end
    end

endmodule

// ===== design/playfair_digraph_cipher.sv =====
// A text word that closes a pair passes the slot read, grid read and result registers and
// holds the input through ST_SLOT, ST_EMIT_A and ST_EMIT_B (the two EMIT states twice for a
// doubled letter at message end); the result side can stall it. Clear, key letter and
// opening text words stay in idle; finish walks the alphabet one letter per cycle over the
// single grid write port. Reset clears seen flags, fill index, held letter and mode; grid and
// slot memory contents are kept and are only valid once written.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// 5x5 playfair cipher: key grid build and digraph encrypt/decrypt over
// synchronous grid and slot memories
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_defines.svh"

module playfair_digraph_cipher import pfc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pfc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pfc_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SLOT,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    // row of a grid slot below 25
    function automatic logic [2:0] row_of(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5) r = 3'd1;
        else r = 3'd0;
        return r;
    endfunction

    // column of a grid slot given its row
    function automatic logic [2:0] col_of(input logic [4:0] p, input logic [2:0] r);
        logic [4:0] t;
        t = p - {r, 2'b00} - {2'b00, r};
        return t[2:0];
    endfunction

    // one step around a row or column, forward or back
    function automatic logic [2:0] step_mod(input logic [2:0] x, input logic back);
        logic [3:0] s;
        s = {1'b0, x} + (back ? {1'b0, SIDE - 3'd1} : 4'd1);
        if (s >= {1'b0, SIDE}) s = s - {1'b0, SIDE};
        return s[2:0];
    endfunction

    // slot from row and column
    function automatic logic [4:0] slot_at(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    state_t     state_reg;
    logic       mode_reg;
    logic [ALPHA_N-1:0] seen_reg;
    logic [4:0] fill_reg;
    logic [4:0] held_letter_reg;
    logic       held_valid_reg;
    logic [4:0] walk_reg;
    logic       seen_a_reg;
    logic       seen_b_reg;
    logic       last_reg;
    logic       rep_reg;
    logic [4:0] oa_reg;
    logic [4:0] ob_reg;

    // key grid and letter position memories
    logic [4:0] grid_mem [GRID_N];
    logic [4:0] slot_mem [ALPHA_N];
    logic [4:0] slot_rd_a_reg;
    logic [4:0] slot_rd_b_reg;
    logic [4:0] grid_rd_reg;

    logic       accept;
    logic [4:0] letter_in;
    logic       letter_ok;
    logic [4:0] place_letter;
    logic       place_req;
    logic       place_en;
    logic       pair_go;
    logic [4:0] pair_a;
    logic [4:0] pair_b;
    logic       pair_last;
    logic       pair_rep;
    logic       held_valid_next;
    logic [4:0] held_letter_next;
    logic       text_go;
    logic [4:0] pos_a;
    logic [4:0] pos_b;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] oa_calc;
    logic [4:0] ob_calc;
    logic       grid_rd_en;
    logic [4:0] grid_rd_addr;
    logic       out_space;
    logic       out_push;
    pfc_out_t   out_word;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // J folds into I
    assign letter_in = (s_data.letter == LET_J) ? LET_I : s_data.letter;
    assign letter_ok = (letter_in <= LET_Z);

    // letter placement, shared by key words and the finish walk
    assign place_letter = (state_reg == ST_FILL) ? walk_reg : letter_in;
    assign place_req    = (state_reg == ST_FILL) ||
                          (accept && s_data.func == FUNC_KEY);
    assign place_en     = place_req && (place_letter <= LET_Z) &&
                          (place_letter != LET_J) && (fill_reg < GRID_N) &&
                          !seen_reg[place_letter];

    // text word pairing decision
    always_comb begin
        pair_go          = 1'b0;
        pair_a           = held_letter_reg;
        pair_b           = LET_X;
        pair_last        = s_data.last;
        pair_rep         = 1'b0;
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        if (!letter_ok) begin
            // bad letter: only a last mark flushes a held letter
            if (s_data.last && held_valid_reg) begin
                pair_go         = 1'b1;
                held_valid_next = 1'b0;
            end
        end else if (!held_valid_reg) begin
            if (s_data.last) begin
                pair_go = 1'b1;
                pair_a  = letter_in;
            end else begin
                held_letter_next = letter_in;
                held_valid_next  = 1'b1;
            end
        end else if (!mode_reg && held_letter_reg == letter_in) begin
            // doubled letter: pad with X, same letter opens next pair
            pair_go         = 1'b1;
            pair_rep        = s_data.last;
            held_valid_next = !s_data.last;
        end else begin
            pair_go         = 1'b1;
            pair_b          = letter_in;
            held_valid_next = 1'b0;
        end
    end

    assign text_go = accept && (s_data.func == FUNC_TEXT) && pair_go;

    // slot lookup result to cipher slots
    assign pos_a   = seen_a_reg ? slot_rd_a_reg : 5'd0;
    assign pos_b   = seen_b_reg ? slot_rd_b_reg : 5'd0;
    assign ra      = row_of(pos_a);
    assign ca      = col_of(pos_a, ra);
    assign rb      = row_of(pos_b);
    assign cb      = col_of(pos_b, rb);

    always_comb begin
        if (ra == rb) begin
            oa_calc = slot_at(ra, step_mod(ca, mode_reg));
            ob_calc = slot_at(rb, step_mod(cb, mode_reg));
        end else if (ca == cb) begin
            oa_calc = slot_at(step_mod(ra, mode_reg), ca);
            ob_calc = slot_at(step_mod(rb, mode_reg), cb);
        end else begin
            oa_calc = slot_at(ra, cb);
            ob_calc = slot_at(rb, ca);
        end
    end

    // result push and grid read scheduling
    assign out_push = ((state_reg == ST_EMIT_A) || (state_reg == ST_EMIT_B)) && out_space;
    assign out_word.out_letter = grid_rd_reg;
    assign out_word.out_last   = (state_reg == ST_EMIT_B) && last_reg && !rep_reg;

    always_comb begin
        grid_rd_en   = 1'b0;
        grid_rd_addr = oa_reg;
        unique case (state_reg)
            ST_SLOT: begin
                grid_rd_en   = 1'b1;
                grid_rd_addr = oa_calc;
            end
            ST_EMIT_A: begin
                grid_rd_en   = out_push;
                grid_rd_addr = ob_reg;
            end
            ST_EMIT_B: begin
                grid_rd_en   = out_push && rep_reg;
                grid_rd_addr = oa_reg;
            end
            default: begin
                grid_rd_en   = 1'b0;
                grid_rd_addr = oa_reg;
            end
        endcase
    end

    // grid memory
    always_ff @(posedge aclk) begin
        if (place_en) begin
            grid_mem[fill_reg] <= place_letter;
        end
        if (grid_rd_en) begin
            grid_rd_reg <= grid_mem[grid_rd_addr];
        end
    end

    // letter position memory, two read ports
    always_ff @(posedge aclk) begin
        if (place_en) begin
            slot_mem[place_letter] <= fill_reg;
        end
        if (text_go) begin
            slot_rd_a_reg <= slot_mem[pair_a];
            slot_rd_b_reg <= slot_mem[pair_b];
        end
    end

    // sequencer and key state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= 1'b0;
            seen_reg       <= '0;
            fill_reg       <= '0;
            held_valid_reg <= 1'b0;
            held_letter_reg <= '0;
            walk_reg       <= '0;
            rep_reg        <= 1'b0;
            last_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (place_en) begin
                seen_reg[place_letter] <= 1'b1;
                fill_reg               <= fill_reg + 5'd1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (s_data.func)
                            FUNC_CLEAR: begin
                                seen_reg       <= '0;
                                fill_reg       <= '0;
                                held_valid_reg <= 1'b0;
                            end
                            FUNC_KEY: begin
                                state_reg <= ST_IDLE;
                            end
                            FUNC_FINISH: begin
                                walk_reg  <= '0;
                                state_reg <= ST_FILL;
                            end
                            FUNC_TEXT: begin
                                held_valid_reg  <= held_valid_next;
                                held_letter_reg <= held_letter_next;
                                if (pair_go) begin
                                    seen_a_reg <= seen_reg[pair_a];
                                    seen_b_reg <= seen_reg[pair_b];
                                    last_reg   <= pair_last;
                                    rep_reg    <= pair_rep;
                                    state_reg  <= ST_SLOT;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    walk_reg <= walk_reg + 5'd1;
                    if (walk_reg == LET_Z) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SLOT: begin
                    oa_reg    <= oa_calc;
                    ob_reg    <= ob_calc;
                    state_reg <= ST_EMIT_A;
                end
                ST_EMIT_A: begin
                    if (out_push) begin
                        state_reg <= ST_EMIT_B;
                    end
                end
                ST_EMIT_B: begin
                    if (out_push) begin
                        if (rep_reg) begin
                            rep_reg   <= 1'b0;
                            state_reg <= ST_EMIT_A;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    pfc_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .push_word (out_word),
        .space     (out_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // checks
    `PFC_ASSERT_SAME(a_fill_count, aclk, aresetn, 1'b1, $countones(seen_reg) == int'(fill_reg), "fill index out of step with placed letters")
    `PFC_ASSERT_SAME(a_place_room, aclk, aresetn, place_en, fill_reg < GRID_N, "letter placed into a full grid")
    `PFC_ASSERT_SAME(a_held_letter, aclk, aresetn, held_valid_reg, (held_letter_reg <= LET_Z) && (held_letter_reg != LET_J), "held letter is not a grid letter")
    `PFC_ASSERT_NEXT(a_pair_start, aclk, aresetn, text_go, state_reg == ST_SLOT, "pair lookup did not start after text word")

endmodule

// ===== tb/playfair_checker.sv =====
// ----------------------------------------------------------------------------
// playfair_checker
// watches the input, result and mode channels of the playfair cipher, keeps
// its own key grid and pair state, predicts every result word and compares
// each accepted result word field by field against the oldest prediction
// ----------------------------------------------------------------------------
module playfair_checker import pfc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  pfc_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  pfc_out_t m_data,
    input  logic     cfg_valid,
    input  logic     cfg_ready,
    input  logic     cfg_data,
    output int       fail_count,
    output int       pending
);

    // key grid, row-major, and the slot of each placed letter
    logic [4:0]  key_grid [25];
    logic [4:0]  grid_pos [26];
    logic [25:0] placed;
    int unsigned next_slot;

    // first letter of an open pair
    logic [4:0]  open_letter;
    logic        open_valid;
    logic        decrypt_mode;

    // predicted result words, oldest first
    pfc_out_t    cipher_q [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // letters never placed are taken to sit at slot 0
    function automatic int unsigned pos_of(input logic [4:0] l);
        if (l > LET_Z || !placed[l])
            return 0;
        return (grid_pos[l] < GRID_N) ? int'(grid_pos[l]) : 0;
    endfunction

    task automatic place_key(input logic [4:0] l);
        if (l > LET_Z || l == LET_J || placed[l] || next_slot >= 25)
            return;
        key_grid[next_slot] = l;
        grid_pos[l] = 5'(next_slot);
        placed[l] = 1'b1;
        next_slot++;
    endtask

    // one digraph: same row, same column or rectangle
    task automatic push_pair(input logic [4:0] a, input logic [4:0] b, input logic lst);
        int unsigned ra, ca, rb, cb, shift, oa, ob;
        pfc_out_t    w;
        ra = pos_of(a) / 5;
        ca = pos_of(a) % 5;
        rb = pos_of(b) / 5;
        cb = pos_of(b) % 5;
        shift = decrypt_mode ? 4 : 1;
        if (ra == rb) begin
            oa = ra * 5 + (ca + shift) % 5;
            ob = rb * 5 + (cb + shift) % 5;
        end else if (ca == cb) begin
            oa = ((ra + shift) % 5) * 5 + ca;
            ob = ((rb + shift) % 5) * 5 + cb;
        end else begin
            oa = ra * 5 + cb;
            ob = rb * 5 + ca;
        end
        w.out_letter = key_grid[oa];
        w.out_last   = 1'b0;
        cipher_q.push_back(w);
        w.out_letter = key_grid[ob];
        w.out_last   = lst;
        cipher_q.push_back(w);
    endtask

    // state update and predicted results for one input word
    task automatic predict_word(input pfc_in_t w);
        logic [4:0] l;
        int         c;
        l = (w.letter == LET_J) ? LET_I : w.letter;
        case (w.func)
            FUNC_CLEAR: begin
                placed     = '0;
                next_slot  = 0;
                open_valid = 1'b0;
            end
            FUNC_KEY: begin
                place_key(l);
            end
            FUNC_FINISH: begin
                for (c = 0; c < ALPHA_N; c++)
                    place_key(5'(c));
            end
            default: begin
                if (l > LET_Z) begin
                    // dropped letter, but last still flushes a held one
                    if (w.last && open_valid) begin
                        push_pair(open_letter, LET_X, 1'b1);
                        open_valid = 1'b0;
                    end
                end else if (!open_valid) begin
                    if (w.last) begin
                        push_pair(l, LET_X, 1'b1);
                    end else begin
                        open_letter = l;
                        open_valid  = 1'b1;
                    end
                end else if (!decrypt_mode && open_letter == l) begin
                    // doubled letter: pad with x, second letter opens next pair
                    push_pair(open_letter, LET_X, 1'b0);
                    if (w.last) begin
                        push_pair(l, LET_X, 1'b1);
                        open_valid = 1'b0;
                    end else begin
                        open_letter = l;
                    end
                end else begin
                    push_pair(open_letter, l, w.last);
                    open_valid = 1'b0;
                end
            end
        endcase
    endtask

    // result words are checked before the input word of the same edge
    always @(posedge aclk) begin
        pfc_out_t want;
        if (!aresetn) begin
            cipher_q.delete();
            for (int i = 0; i < 25; i++)
                key_grid[i] = '0;
            for (int i = 0; i < 26; i++)
                grid_pos[i] = '0;
            placed       = '0;
            next_slot    = 0;
            open_letter  = '0;
            open_valid   = 1'b0;
            decrypt_mode = 1'b0;
            fail_count   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch($sformatf("result word letter %0d last %0d not expected",
                                              m_data.out_letter, m_data.out_last));
                end else begin
                    want = cipher_q.pop_front();
                    if (m_data.out_letter !== want.out_letter)
                        report_mismatch($sformatf("out_letter got %0d expected %0d",
                                                  m_data.out_letter, want.out_letter));
                    if (m_data.out_last !== want.out_last)
                        report_mismatch($sformatf("out_last got %0d expected %0d",
                                                  m_data.out_last, want.out_last));
                end
            end
            if (cfg_valid && cfg_ready)
                decrypt_mode = cfg_data;
            if (s_valid && s_ready)
                predict_word(s_data);
        end
        pending = cipher_q.size();
    end

endmodule

// ===== tb/tb_playfair_digraph_cipher.sv =====
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher
// drives key, finish, clear and text words into the playfair cipher with
// bursty input and a stalling result side, switches encrypt/decrypt mode
// between drained phases, and gives the verdict from the checker's count
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher;
    import pfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int TARGET_WORDS   = 460;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pfc_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    pfc_out_t m_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    int fail_count;
    int pending;
    int idle_cycles  = 0;
    int burst_left   = 0;
    int fed_words    = 0;
    logic [15:0] stall_pattern = '1;
    int pattern_age  = 0;

    playfair_digraph_cipher i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    playfair_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // receiver stalls from a rotating pattern that is redrawn now and then
    always @(negedge aclk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern <= '1;
                1:       stall_pattern <= 16'($urandom) | 16'h0001;
                2:       stall_pattern <= 16'($urandom) | 16'($urandom) | 16'h0001;
                default: stall_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
            endcase
            pattern_age <= $urandom_range(20, 80);
        end else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            pattern_age <= pattern_age - 1;
        end
        m_ready <= stall_pattern[0];
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input word; a burst may open with a random gap
    task automatic send_word(input pfc_func_t f, input logic [4:0] l, input logic lst);
        pfc_in_t w;
        w.func   = f;
        w.letter = l;
        w.last   = lst;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!(f == FUNC_KEY && l > LET_Z))
            fed_words++;
    endtask

    // hold input until all results are out and the block has settled
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_mode(input logic dec);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= dec;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly plain letters, some j, a few out-of-range codes
    function automatic logic [4:0] pick_letter();
        case ($urandom_range(0, 15))
            0:       return 5'($urandom);
            1:       return LET_J;
            default: return 5'($urandom_range(0, 25));
        endcase
    endfunction

    // message with frequent doubled letters, last on the final word
    task automatic send_message(input int len);
        logic [4:0] prev;
        logic [4:0] l;
        prev = pick_letter();
        for (int i = 0; i < len; i++) begin
            l = ($urandom_range(0, 3) == 0) ? prev : pick_letter();
            send_word(FUNC_TEXT, l, i == len - 1);
            prev = l;
        end
    endtask

    task automatic run_phase();
        case ($urandom_range(0, 9))
            0: begin
                // noise: any function, any code
                repeat ($urandom_range(3, 10))
                    send_word(pfc_func_t'($urandom_range(0, 3)), 5'($urandom), 1'($urandom));
            end
            1: begin
                // text under whatever grid and flags are left
                repeat ($urandom_range(1, 3))
                    send_message($urandom_range(1, 14));
            end
            default: begin
                // new key then messages
                send_word(FUNC_CLEAR, 5'($urandom), 1'($urandom));
                repeat ($urandom_range(0, 12))
                    send_word(FUNC_KEY, pick_letter(), 1'($urandom));
                send_word(FUNC_FINISH, 5'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 3))
                    send_message($urandom_range(1, 14));
            end
        endcase
    endtask

    initial begin
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        aresetn   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // key with duplicate, j and out-of-range codes, then finish
        send_word(FUNC_KEY, 5'd15, 1'b0);
        send_word(FUNC_KEY, LET_J, 1'b1);
        send_word(FUNC_KEY, 5'd31, 1'b0);
        send_word(FUNC_KEY, 5'd15, 1'b0);
        send_word(FUNC_FINISH, 5'd0, 1'b0);
        // grid full, key letter ignored
        send_word(FUNC_KEY, 5'd1, 1'b0);
        // rectangle pair, first and last letters
        send_word(FUNC_TEXT, 5'd0, 1'b0);
        send_word(FUNC_TEXT, LET_Z, 1'b0);
        // doubled letter, then dropped code with last flushing the held letter
        send_word(FUNC_TEXT, 5'd4, 1'b0);
        send_word(FUNC_TEXT, 5'd4, 1'b0);
        send_word(FUNC_TEXT, 5'd30, 1'b1);
        // single letter message padded with x
        send_word(FUNC_TEXT, LET_I, 1'b1);
        // dropped code with nothing held
        send_word(FUNC_TEXT, 5'd31, 1'b1);
        send_word(FUNC_TEXT, LET_J, 1'b0);
        send_word(FUNC_TEXT, LET_X, 1'b0);
        // doubled x at message end gives four words
        send_word(FUNC_TEXT, LET_X, 1'b0);
        send_word(FUNC_TEXT, LET_X, 1'b1);
        // same row, then same column
        send_word(FUNC_TEXT, 5'd0, 1'b0);
        send_word(FUNC_TEXT, 5'd2, 1'b0);
        send_word(FUNC_TEXT, 5'd15, 1'b0);
        send_word(FUNC_TEXT, 5'd3, 1'b0);
        // clear drops the held letter, then an unplaced letter
        send_word(FUNC_TEXT, 5'd5, 1'b0);
        send_word(FUNC_CLEAR, 5'd0, 1'b0);
        send_word(FUNC_TEXT, 5'd6, 1'b1);

        // random phases, mode switched between drained phases
        write_mode(1'b1);
        while (fed_words < TARGET_WORDS) begin
            if ($urandom_range(0, 4) == 0)
                write_mode(1'($urandom));
            run_phase();
        end

        wait_drained();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/pfc_pkg.sv
design/pfc_out_stage.sv
design/playfair_digraph_cipher.sv
tb/playfair_checker.sv
tb/tb_playfair_digraph_cipher.sv
